>>> src/zpg_pkg.sv
// Shared constants and cosine table functions for the zone plate pattern generator.
// No dependencies; imported by every module of the block.
package zpg_pkg;

    localparam int PIXEL_W = 12;
    localparam int SIDE_W = 13;
    localparam int GRAY_W = 8;
    localparam int MAX_SIDE_DEF = 4096;
    localparam int PHASE_BITS_DEF = 12;
    localparam logic [SIDE_W-1:0] SIDE_RESET = 13'd512;
    localparam logic [GRAY_W-1:0] GRAY_MID = 8'd128;
    localparam logic [63:0] Q32_ONE = 64'h1_0000_0000;
    localparam logic [63:0] TWO_PI_Q48 = 64'h0006_487E_D511_0B46;

    function automatic logic [63:0] cos_q32(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        x2 = (x * x) >> 32;
        t = Q32_ONE;
        t = Q32_ONE - (((x2 * t) >> 32) / 132);
        t = Q32_ONE - (((x2 * t) >> 32) / 90);
        t = Q32_ONE - (((x2 * t) >> 32) / 56);
        t = Q32_ONE - (((x2 * t) >> 32) / 30);
        t = Q32_ONE - (((x2 * t) >> 32) / 12);
        t = Q32_ONE - (((x2 * t) >> 32) / 2);
        return t;
    endfunction

    function automatic logic [63:0] sin_q32(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        x2 = (x * x) >> 32;
        t = Q32_ONE;
        t = Q32_ONE - (((x2 * t) >> 32) / 156);
        t = Q32_ONE - (((x2 * t) >> 32) / 110);
        t = Q32_ONE - (((x2 * t) >> 32) / 72);
        t = Q32_ONE - (((x2 * t) >> 32) / 42);
        t = Q32_ONE - (((x2 * t) >> 32) / 20);
        t = Q32_ONE - (((x2 * t) >> 32) / 6);
        return (x * t) >> 32;
    endfunction

    // Quarter-wave entry: bit 7 flags a nonzero fraction, bits 6:0 hold floor(255*|c|/2).
    function automatic logic [GRAY_W-1:0] rom_entry(input logic [63:0] q,
                                                    input int unsigned pb);
        logic [63:0] eighth;
        logic [63:0] k;
        logic [63:0] angle;
        logic [63:0] mag;
        logic [63:0] u;
        logic use_sin;
        eighth = 64'd1 << (pb - 3);
        use_sin = (q > eighth);
        k = use_sin ? ((eighth << 1) - q) : q;
        angle = (k * TWO_PI_Q48 + (64'd1 << (pb + 15))) >> (pb + 16);
        mag = use_sin ? sin_q32(angle) : cos_q32(angle);
        if (mag > Q32_ONE) begin
            mag = Q32_ONE;
        end
        u = mag * 64'd255;
        return {(|u[32:0]), u[39:33]};
    endfunction

endpackage

>>> src/zpg_front.sv
// Front end: doubled center offsets, their squares and the sum of squares.
// Depends on zpg_pkg.
module zpg_front #(
    parameter int MAX_SIDE = zpg_pkg::MAX_SIDE_DEF,
    localparam int AW = ((zpg_pkg::PIXEL_W + 1) > $clog2(MAX_SIDE)) ?
                        (zpg_pkg::PIXEL_W + 1) : $clog2(MAX_SIDE),
    localparam int NW = $clog2(MAX_SIDE + 1),
    localparam int SW = 2 * AW + 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [zpg_pkg::PIXEL_W-1:0]  i_x,
    input  logic [zpg_pkg::PIXEL_W-1:0]  i_y,
    input  logic [NW-1:0]                i_side,
    output logic                         o_valid,
    output logic [SW-1:0]                o_sum
);
    import zpg_pkg::*;

    logic [AW-1:0]   two_x;
    logic [AW-1:0]   two_y;
    logic [AW-1:0]   sm1;
    logic [AW-1:0]   n_ax;
    logic [AW-1:0]   n_ay;
    logic [AW-1:0]   r_ax;
    logic [AW-1:0]   r_ay;
    logic [2*AW-1:0] r_sqx;
    logic [2*AW-1:0] r_sqy;
    logic [SW-1:0]   r_sum;
    logic            r_v1;
    logic            r_v2;
    logic            r_v3;

    always_comb begin
        two_x = AW'({i_x, 1'b0});
        two_y = AW'({i_y, 1'b0});
        sm1 = AW'(i_side - NW'(1));
        n_ax = (two_x >= sm1) ? (two_x - sm1) : (sm1 - two_x);
        n_ay = (two_y >= sm1) ? (two_y - sm1) : (sm1 - two_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax <= n_ax;
            r_ay <= n_ay;
            r_sqx <= (2*AW)'(r_ax) * (2*AW)'(r_ax);
            r_sqy <= (2*AW)'(r_ay) * (2*AW)'(r_ay);
            r_sum <= SW'(r_sqx) + SW'(r_sqy);
        end
    end

    assign o_valid = r_v3;
    assign o_sum = r_sum;

endmodule

>>> src/zpg_div_cell.sv
// One restoring division cell: shifts in one dividend bit, produces one quotient bit.
// Depends on zpg_pkg.
module zpg_div_cell #(
    parameter int MAX_SIDE = zpg_pkg::MAX_SIDE_DEF,
    parameter int PHASE_BITS = zpg_pkg::PHASE_BITS_DEF,
    localparam int AW = ((zpg_pkg::PIXEL_W + 1) > $clog2(MAX_SIDE)) ?
                        (zpg_pkg::PIXEL_W + 1) : $clog2(MAX_SIDE),
    localparam int NW = $clog2(MAX_SIDE + 1),
    localparam int RW = $clog2(MAX_SIDE),
    localparam int DW = 2 * AW + 1 + PHASE_BITS - 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [RW-1:0] i_rem,
    input  logic [DW-1:0] i_dvd,
    input  logic [NW-1:0] i_divisor,
    output logic          o_valid,
    output logic [RW-1:0] o_rem,
    output logic [DW-1:0] o_dvd
);
    import zpg_pkg::*;

    logic [RW:0]   trial;
    logic [RW:0]   dvs;
    logic [RW:0]   diff;
    logic          ge;
    logic [RW-1:0] n_rem;
    logic [DW-1:0] n_dvd;
    logic          r_valid;
    logic [RW-1:0] r_rem;
    logic [DW-1:0] r_dvd;

    always_comb begin
        trial = {i_rem, i_dvd[DW-1]};
        dvs = (RW+1)'(i_divisor);
        ge = (trial >= dvs);
        diff = trial - dvs;
        n_rem = ge ? diff[RW-1:0] : trial[RW-1:0];
        n_dvd = {i_dvd[DW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_dvd <= n_dvd;
        end
    end

    assign o_valid = r_valid;
    assign o_rem = r_rem;
    assign o_dvd = r_dvd;

endmodule

>>> src/zpg_phase_rom.sv
// Phase rounding, quarter-wave folding and cosine table lookup.
// Depends on zpg_pkg (table contents from rom_entry).
module zpg_phase_rom #(
    parameter int PHASE_BITS = zpg_pkg::PHASE_BITS_DEF,
    localparam int ROM_N = (1 << (PHASE_BITS - 2)) + 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [PHASE_BITS:0]         i_quot,
    output logic                        o_valid,
    output logic [zpg_pkg::GRAY_W-1:0]  o_gray
);
    import zpg_pkg::*;

    localparam logic [PHASE_BITS:0] FULL = (PHASE_BITS+1)'(1) << PHASE_BITS;
    localparam logic [PHASE_BITS:0] HALF = (PHASE_BITS+1)'(1) << (PHASE_BITS - 1);
    localparam logic [PHASE_BITS:0] QUARTER = (PHASE_BITS+1)'(1) << (PHASE_BITS - 2);

    logic [GRAY_W-1:0]     rom_w [ROM_N];
    logic [PHASE_BITS+1:0] q_inc;
    logic [PHASE_BITS:0]   fold;
    logic                  n_neg;
    logic [PHASE_BITS-1:0] r_p;
    logic [PHASE_BITS-2:0] r_qidx;
    logic                  r_neg2;
    logic                  r_neg3;
    logic [GRAY_W-1:0]     r_entry;
    logic                  r_v1;
    logic                  r_v2;
    logic                  r_v3;

    for (genvar g = 0; g < ROM_N; g++) begin : g_rom
        assign rom_w[g] = rom_entry(64'(g), PHASE_BITS);
    end

    always_comb begin
        q_inc = (PHASE_BITS+2)'(i_quot) + (PHASE_BITS+2)'(1);
        fold = (PHASE_BITS+1)'(r_p);
        n_neg = 1'b0;
        if (fold > HALF) begin
            fold = FULL - fold;
        end
        if (fold > QUARTER) begin
            fold = HALF - fold;
            n_neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= q_inc[PHASE_BITS:1];
            r_qidx <= fold[PHASE_BITS-2:0];
            r_neg2 <= n_neg;
            r_entry <= rom_w[r_qidx];
            r_neg3 <= r_neg2;
        end
    end

    assign o_valid = r_v3;
    assign o_gray = r_neg3 ?
                    (GRAY_MID - {1'b0, r_entry[6:0]} - GRAY_W'(r_entry[7])) :
                    (GRAY_MID + {1'b0, r_entry[6:0]});

endmodule

>>> src/zone_plate_pattern_generator.sv
// Top level of the circular zone plate pattern generator.
// Depends on zpg_pkg, zpg_front, zpg_div_cell and zpg_phase_rom.
//
// Usage:
//   Input stream: one transfer per pixel, tdata = {pixel_y, pixel_x}.
//   Output stream: one transfer per pixel, tdata = gray_level, in input order.
//   Config: pulse i_cfg_we with the square image side on i_cfg_wdata while the
//   block holds no pixel in flight. A side of 0 acts as 1, above MAX_SIDE as MAX_SIDE.
//   Throughput: one pixel per clock while the skid entry is empty. The phase divide
//   is a chain of restoring division cells, one quotient bit per cell, all cells
//   working in parallel. Pixel path: front end, division cell chain, phase table,
//   output register; AW = max(13, clog2(MAX_SIDE)) is the front end offset width.
//   Stall: an output register plus one skid entry; the pipeline and input ready
//   hold only while the skid entry is occupied.
//   Reset: image side returns to 512, all pipeline and output valids clear.
module zone_plate_pattern_generator #(
    parameter int MAX_SIDE = zpg_pkg::MAX_SIDE_DEF,
    parameter int PHASE_BITS = zpg_pkg::PHASE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [zpg_pkg::SIDE_W-1:0]    i_cfg_wdata,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // [11:0] pixel_x, [23:12] pixel_y
    input  logic [2*zpg_pkg::PIXEL_W-1:0] i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [7:0] gray_level
    output logic [zpg_pkg::GRAY_W-1:0]    o_m_axis_tdata
);
    import zpg_pkg::*;

    localparam int AW = ((PIXEL_W + 1) > $clog2(MAX_SIDE)) ? (PIXEL_W + 1) : $clog2(MAX_SIDE);
    localparam int NW = $clog2(MAX_SIDE + 1);
    localparam int RW = $clog2(MAX_SIDE);
    localparam int SW = 2 * AW + 1;
    localparam int DW = SW + PHASE_BITS - 2;
    localparam int CW = (SIDE_W > NW) ? SIDE_W : NW;

    logic [SIDE_W-1:0] r_image_side;
    logic [CW-1:0]     side_wide;
    logic [NW-1:0]     side_eff;
    logic              pipe_en;
    logic              f_valid;
    logic [SW-1:0]     f_sum;
    logic              c_valid [DW+1];
    logic [RW-1:0]     c_rem [DW+1];
    logic [DW-1:0]     c_dvd [DW+1];
    logic              arr_valid;
    logic [GRAY_W-1:0] arr_gray;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [GRAY_W-1:0] r_out_data;
    logic [GRAY_W-1:0] n_out_data;
    logic              r_skid_valid;
    logic              n_skid_valid;
    logic [GRAY_W-1:0] r_skid_data;
    logic [GRAY_W-1:0] n_skid_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_side <= SIDE_RESET;
        end else if (i_cfg_we) begin
            r_image_side <= i_cfg_wdata;
        end
    end

    always_comb begin
        side_wide = CW'(r_image_side);
        if (side_wide == '0) begin
            side_wide = CW'(1);
        end
        if (side_wide > CW'(MAX_SIDE)) begin
            side_wide = CW'(MAX_SIDE);
        end
        side_eff = NW'(side_wide);
    end

    assign pipe_en = !r_skid_valid;
    assign o_s_axis_tready = pipe_en;

    zpg_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (i_s_axis_tvalid),
        .i_x     (i_s_axis_tdata[PIXEL_W-1:0]),
        .i_y     (i_s_axis_tdata[2*PIXEL_W-1:PIXEL_W]),
        .i_side  (side_eff),
        .o_valid (f_valid),
        .o_sum   (f_sum)
    );

    assign c_valid[0] = f_valid;
    assign c_rem[0] = '0;
    assign c_dvd[0] = {f_sum, {(PHASE_BITS-2){1'b0}}};

    for (genvar g = 0; g < DW; g++) begin : g_cell
        zpg_div_cell #(
            .MAX_SIDE   (MAX_SIDE),
            .PHASE_BITS (PHASE_BITS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (pipe_en),
            .i_valid   (c_valid[g]),
            .i_rem     (c_rem[g]),
            .i_dvd     (c_dvd[g]),
            .i_divisor (side_eff),
            .o_valid   (c_valid[g+1]),
            .o_rem     (c_rem[g+1]),
            .o_dvd     (c_dvd[g+1])
        );
    end

    zpg_phase_rom #(
        .PHASE_BITS (PHASE_BITS)
    ) u_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (c_valid[DW]),
        .i_quot  (c_dvd[DW][PHASE_BITS:0]),
        .o_valid (arr_valid),
        .o_gray  (arr_gray)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data = r_skid_data;
        if (r_skid_valid) begin
            if (i_m_axis_tready) begin
                n_out_data = r_skid_data;
                n_skid_valid = 1'b0;
            end
        end else if (arr_valid) begin
            if (!r_out_valid || i_m_axis_tready) begin
                n_out_valid = 1'b1;
                n_out_data = arr_gray;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_data = arr_gray;
            end
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata = r_out_data;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds data while output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_skid_valid ##1 r_skid_valid) |-> $past(r_out_valid && !i_m_axis_tready))
        else $error("skid entry filled without an output stall");

    a_side_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (side_eff != '0) && (CW'(side_eff) <= CW'(MAX_SIDE)))
        else $error("effective image side out of range");

endmodule
